// ===== design/kst_pkg.sv =====
// Shared constants, opcodes, state encoding and structs for the keyed session table.
// Used by kst_ctrl and keyed_session_table_lru; depends on nothing.
package kst_pkg;

  localparam int TABLE_DEPTH     = 1024;
  localparam int KEY_BITS        = 16;
  localparam int STAMP_BITS      = 32;
  localparam int IDX_BITS        = $clog2(TABLE_DEPTH);
  localparam int CNT_BITS        = $clog2(TABLE_DEPTH + 1);
  localparam int OPCODE_BITS     = 2;
  localparam int CLIENT_KEY_BITS = 16;
  localparam int ACCOUNT_BITS    = 31;
  localparam int SESSION_BITS    = 64;

  typedef enum logic [OPCODE_BITS-1:0] {
    OP_SET    = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_LOOKUP = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [OPCODE_BITS-1:0] op;
    logic [KEY_BITS-1:0]    key;
  } req_t;

  typedef struct packed {
    logic [ACCOUNT_BITS-1:0] account;
    logic [SESSION_BITS-1:0] session_hi;
    logic [SESSION_BITS-1:0] session_lo;
  } data_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [STAMP_BITS-1:0] stamp;
  } tag_t;

  typedef struct packed {
    logic  found;
    data_t data;
  } res_t;

  typedef struct packed {
    logic start;
    logic res_taken;
  } hs_in_t;

  typedef struct packed {
    logic busy;
    logic res_vld;
  } hs_out_t;

endpackage

// ===== design/keyed_session_table_lru.sv =====
// Top level of the keyed session table: input capture, result register and the sequencer.
// Depends on kst_pkg and kst_ctrl.
// A rejected transaction skips the scan and goes straight to the result; a lookup hit adds a
// data store read. The scan reads one tag store entry per cycle.
// The next transaction is accepted once the result of the last one is registered; the result
// register takes a new result only while it is empty or out_stall is low.
// Reset: synchronous on rst_n; no clearing pass, a fill count marks the written slots.
module keyed_session_table_lru
  import kst_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [OPCODE_BITS-1:0]     in_opcode,
  input  logic [CLIENT_KEY_BITS-1:0] in_client_key,
  input  logic [ACCOUNT_BITS-1:0]    in_account_in,
  input  logic [SESSION_BITS-1:0]    in_session_hi_in,
  input  logic [SESSION_BITS-1:0]    in_session_lo_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_found,
  output logic [ACCOUNT_BITS-1:0]    out_account_out,
  output logic [SESSION_BITS-1:0]    out_session_hi_out,
  output logic [SESSION_BITS-1:0]    out_session_lo_out
);

  hs_in_t  hs_i;
  hs_out_t hs_o;
  req_t    req;
  data_t   data_r, data_nxt;
  res_t    res;
  res_t    out_res_r, out_res_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    accept;

  assign in_stall = hs_o.busy;
  assign accept   = in_valid && !in_stall;

  assign req.op  = in_opcode;
  assign req.key = KEY_BITS'(in_client_key);

  assign hs_i.start     = accept;
  assign hs_i.res_taken = hs_o.res_vld && (!out_valid_r || !out_stall);

  always_comb begin
    data_nxt = data_r;
    if (accept) begin
      data_nxt = '{account: in_account_in, session_hi: in_session_hi_in,
                   session_lo: in_session_lo_in};
    end
  end

  always_comb begin
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (hs_i.res_taken) begin
      out_res_nxt   = res;
      out_valid_nxt = 1'b1;
    end
  end

  kst_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .hs_i  (hs_i),
    .req_i (req),
    .data_i(data_r),
    .hs_o  (hs_o),
    .res_o (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r    <= data_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_found          = out_res_r.found;
  assign out_account_out    = out_res_r.data.account;
  assign out_session_hi_out = out_res_r.data.session_hi;
  assign out_session_lo_out = out_res_r.data.session_lo;

endmodule

// ===== design/kst_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// Used for the tag and data stores of the session table; depends on nothing.
module kst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/kst_ctrl.sv =====
// Sequencer of the session table: linear scan of the tag store, slot choice, and write-back or data read.
// Holds the tag and data RAMs (kst_ram); depends on kst_pkg.
module kst_ctrl
  import kst_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  hs_in_t  hs_i,
  input  req_t    req_i,
  input  data_t   data_i,
  output hs_out_t hs_o,
  output res_t    res_o
);

  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(TABLE_DEPTH - 1);

  state_t                state_r, state_nxt;
  logic [IDX_BITS-1:0]   cnt_r, cnt_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic [IDX_BITS-1:0]   rd_idx_r, rd_idx_nxt;
  logic [CNT_BITS-1:0]   fill_r, fill_nxt;
  logic [STAMP_BITS-1:0] next_stamp_r, next_stamp_nxt;
  logic [OPCODE_BITS-1:0] op_r, op_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic                  hit_r, hit_nxt;
  logic [IDX_BITS-1:0]   hit_idx_r, hit_idx_nxt;
  logic                  emp_r, emp_nxt;
  logic [IDX_BITS-1:0]   emp_idx_r, emp_idx_nxt;
  logic                  min_vld_r, min_vld_nxt;
  logic [IDX_BITS-1:0]   min_idx_r, min_idx_nxt;
  logic [STAMP_BITS-1:0] min_stamp_r, min_stamp_nxt;
  res_t                  res_r, res_nxt;

  logic                  req_ok;
  logic                  entry_vld;
  logic [KEY_BITS-1:0]   entry_key;
  logic [IDX_BITS-1:0]   slot;
  logic [STAMP_BITS-1:0] stamp_inc;

  logic                  tag_we, tag_re;
  logic [IDX_BITS-1:0]   tag_waddr, tag_raddr;
  tag_t                  tag_wdata, tag_rd;
  logic [$bits(tag_t)-1:0] tag_rdata;
  logic                  data_we, data_re;
  logic [IDX_BITS-1:0]   data_waddr, data_raddr;
  logic [$bits(data_t)-1:0] data_rdata;

  kst_ram #(
    .WIDTH($bits(tag_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_tag_ram (
    .clk  (clk),
    .we   (tag_we),
    .waddr(tag_waddr),
    .wdata(tag_wdata),
    .re   (tag_re),
    .raddr(tag_raddr),
    .rdata(tag_rdata)
  );

  kst_ram #(
    .WIDTH($bits(data_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_data_ram (
    .clk  (clk),
    .we   (data_we),
    .waddr(data_waddr),
    .wdata(data_i),
    .re   (data_re),
    .raddr(data_raddr),
    .rdata(data_rdata)
  );

  assign tag_rd = tag_t'(tag_rdata);
  assign req_ok = (req_i.key != '0) &&
                  (req_i.op == OP_SET || req_i.op == OP_CLEAR || req_i.op == OP_LOOKUP);

  // Entries at or above the fill count were never written and read as empty.
  assign entry_vld = CNT_BITS'(rd_idx_r) < fill_r;
  assign entry_key = entry_vld ? tag_rd.key : '0;
  assign slot      = hit_r ? hit_idx_r : (emp_r ? emp_idx_r : min_idx_r);
  assign stamp_inc = next_stamp_r + STAMP_BITS'(1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (hs_i.start) begin
          state_nxt = req_ok ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (cnt_r == LAST_IDX) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_nxt = (op_r == OP_LOOKUP && hit_r) ? ST_READ : ST_DONE;
      end
      ST_READ: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (hs_i.res_taken) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cnt_nxt        = cnt_r;
    rd_vld_nxt     = (state_r == ST_SCAN);
    rd_idx_nxt     = cnt_r;
    fill_nxt       = fill_r;
    next_stamp_nxt = next_stamp_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    emp_nxt        = emp_r;
    emp_idx_nxt    = emp_idx_r;
    min_vld_nxt    = min_vld_r;
    min_idx_nxt    = min_idx_r;
    min_stamp_nxt  = min_stamp_r;
    res_nxt        = res_r;
    tag_re         = 1'b0;
    tag_raddr      = cnt_r;
    tag_we         = 1'b0;
    tag_waddr      = slot;
    tag_wdata      = '{key: key_r, stamp: next_stamp_r};
    data_we        = 1'b0;
    data_waddr     = slot;
    data_re        = 1'b0;
    data_raddr     = hit_idx_r;

    if (rd_vld_r) begin
      if (!hit_r && entry_key == key_r) begin
        hit_nxt     = 1'b1;
        hit_idx_nxt = rd_idx_r;
      end
      if (!emp_r && entry_key == '0) begin
        emp_nxt     = 1'b1;
        emp_idx_nxt = rd_idx_r;
      end
      if (entry_key != '0 && (!min_vld_r || tag_rd.stamp < min_stamp_r)) begin
        min_vld_nxt   = 1'b1;
        min_idx_nxt   = rd_idx_r;
        min_stamp_nxt = tag_rd.stamp;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (hs_i.start) begin
          op_nxt      = req_i.op;
          key_nxt     = req_i.key;
          cnt_nxt     = '0;
          hit_nxt     = 1'b0;
          emp_nxt     = 1'b0;
          min_vld_nxt = 1'b0;
          res_nxt     = '0;
        end
      end
      ST_SCAN: begin
        tag_re  = 1'b1;
        cnt_nxt = cnt_r + IDX_BITS'(1);
      end
      ST_DECIDE: begin
        res_nxt.found = hit_r;
        if (op_r == OP_SET) begin
          tag_we         = 1'b1;
          data_we        = 1'b1;
          next_stamp_nxt = (stamp_inc == '0) ? STAMP_BITS'(1) : stamp_inc;
          if (CNT_BITS'(slot) == fill_r) begin
            fill_nxt = fill_r + CNT_BITS'(1);
          end
        end else if (op_r == OP_CLEAR) begin
          tag_we    = hit_r;
          tag_wdata = '0;
        end else begin
          data_re = hit_r;
        end
      end
      ST_READ: begin
        res_nxt.data = data_t'(data_rdata);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rd_vld_r     <= 1'b0;
      fill_r       <= '0;
      next_stamp_r <= STAMP_BITS'(1);
    end else begin
      state_r      <= state_nxt;
      rd_vld_r     <= rd_vld_nxt;
      fill_r       <= fill_nxt;
      next_stamp_r <= next_stamp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    rd_idx_r    <= rd_idx_nxt;
    op_r        <= op_nxt;
    key_r       <= key_nxt;
    hit_r       <= hit_nxt;
    hit_idx_r   <= hit_idx_nxt;
    emp_r       <= emp_nxt;
    emp_idx_r   <= emp_idx_nxt;
    min_vld_r   <= min_vld_nxt;
    min_idx_r   <= min_idx_nxt;
    min_stamp_r <= min_stamp_nxt;
    res_r       <= res_nxt;
  end

  assign hs_o.busy    = (state_r != ST_IDLE);
  assign hs_o.res_vld = (state_r == ST_DONE);
  assign res_o        = res_r;

endmodule
